// ===== hw/rtl/ork_pkg.sv =====
// ============================================================================
// ork_pkg - shared types and constants of the ODE integrator
// Fixed-point format, register map, method codes and the structs that
// travel between the config block, the core and the multiplier.
// ============================================================================
package ork_pkg;

  // Fixed-point format: signed Q(DATA_W-FRAC_BITS).FRAC_BITS
  localparam int FRAC_BITS = 16;
  localparam int STEP_BITS = 10;
  localparam int DATA_W    = 32;
  localparam int H_W       = 19;

  // Shared multiplier: 33b signed x 36b signed, full product kept
  localparam int MA_W = 33;
  localparam int MB_W = 36;
  localparam int P_W  = MA_W + MB_W;

  // APB register map
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_STEP_SIZE = 1'b0;
  localparam logic REG_METHOD    = 1'b1;

  // Method codes (code 3 runs as fourth order)
  localparam logic [1:0] METHOD_EULER = 2'd0;
  localparam logic [1:0] METHOD_HEUN  = 2'd1;
  localparam logic [1:0] METHOD_RK4   = 2'd2;

  localparam logic [H_W-1:0] H_RESET = H_W'(6554);

  typedef logic signed [DATA_W-1:0] fx_t;

  typedef struct packed {
    logic [H_W-1:0] h;
    logic [1:0]     method;
  } cfg_t;

  typedef struct packed {
    fx_t                  x_start;
    fx_t                  y_start;
    logic [STEP_BITS-1:0] step_count;
  } item_t;

  typedef struct packed {
    logic valid;
    fx_t  y_final;
    logic overflow;
  } res_t;

  typedef struct packed {
    logic            en;
    logic [MA_W-1:0] a;
    logic [MB_W-1:0] b;
  } mul_req_t;

endpackage

// ===== hw/rtl/ork_in_if.sv =====
// ============================================================================
// ork_in_if - start-point channel
// Valid/ready channel carrying the start point and the step count.
// ============================================================================
interface ork_in_if;
  logic                          valid;
  logic                          ready;
  ork_pkg::fx_t                  x_start;
  ork_pkg::fx_t                  y_start;
  logic [ork_pkg::STEP_BITS-1:0] step_count;

  modport source (output valid, output x_start, output y_start, output step_count,
                  input ready);
  modport sink   (input valid, input x_start, input y_start, input step_count,
                  output ready);
endinterface

// ===== hw/rtl/ork_out_if.sv =====
// ============================================================================
// ork_out_if - result channel
// Valid/ready channel carrying the final y and the saturation flag.
// ============================================================================
interface ork_out_if;
  logic         valid;
  logic         ready;
  ork_pkg::fx_t y_final;
  logic         overflow;

  modport source (output valid, output y_final, output overflow, input ready);
  modport sink   (input valid, input y_final, input overflow, output ready);
endinterface

// ===== hw/rtl/ork_mul_unit.sv =====
// ============================================================================
// ork_mul_unit - shared signed multiplier
// One registered 33x36 signed multiply, issued by the core sequencer.
// ============================================================================
module ork_mul_unit (
  input  logic                              clk_i,
  input  ork_pkg::mul_req_t                 req_i,
  output logic signed [ork_pkg::P_W-1:0]    p_o
);

  logic signed [ork_pkg::P_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      p_q <= $signed(req_i.a) * $signed(req_i.b);
    end
  end

  assign p_o = p_q;

endmodule

// ===== hw/rtl/ork_cfg_regs.sv =====
// ============================================================================
// ork_cfg_regs - APB configuration registers
// Holds step size and method; zero-wait writes and reads.
// ============================================================================
module ork_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ork_pkg::PADDR_W-1:0]   paddr,
  input  logic [ork_pkg::PDATA_W-1:0]   pwdata,
  output logic [ork_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output ork_pkg::cfg_t                 cfg_o
);

  ork_pkg::cfg_t cfg_q, cfg_d;
  logic          reg_idx;
  logic          wr_en;

  assign pready  = 1'b1;
  // word index; byte offset bits are ignored
  assign reg_idx = paddr[ork_pkg::PADDR_W-1];
  assign wr_en   = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        ork_pkg::REG_STEP_SIZE: cfg_d.h      = pwdata[ork_pkg::H_W-1:0];
        ork_pkg::REG_METHOD:    cfg_d.method = pwdata[1:0];
        default:                cfg_d        = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ork_pkg::REG_STEP_SIZE: prdata = ork_pkg::PDATA_W'(cfg_q.h);
      ork_pkg::REG_METHOD:    prdata = ork_pkg::PDATA_W'(cfg_q.method);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.h      <= ork_pkg::H_RESET;
      cfg_q.method <= ork_pkg::METHOD_RK4;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/ork_core.sv =====
// ============================================================================
// ork_core - step sequencer and datapath registers
// Walks the slope stages of each step, driving the shared multiplier for
// x*y, h*k and the reciprocal multiply that divides by three.
// ============================================================================
module ork_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ork_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ork_pkg::item_t item_i,
  output ork_pkg::res_t res_o,
  input  logic          res_ready_i
);

  localparam int DATA_W   = ork_pkg::DATA_W;
  localparam int ACC_W    = ork_pkg::MB_W;
  localparam int Q_W      = ork_pkg::P_W - ork_pkg::FRAC_BITS;
  localparam int SAT_W    = Q_W;
  localparam int MAG_W    = 34;
  // floor(n/3) = (n * RECIP3) >> RCP_SHIFT, exact for n < 2^RCP_SHIFT (odd shift)
  localparam int RCP_SHIFT = MAG_W - 1;
  localparam logic [ork_pkg::MA_W-1:0] RECIP3 =
    ork_pkg::MA_W'(((longint'(1) <<< RCP_SHIFT) + 1) / 3);
  localparam ork_pkg::fx_t FX_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam ork_pkg::fx_t FX_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [10:0] {
    S_IDLE       = 11'b00000000001,
    S_EVAL_MUL   = 11'b00000000010,
    S_EVAL_T2    = 11'b00000000100,
    S_EVAL_K     = 11'b00000001000,
    S_ACC        = 11'b00000010000,
    S_SCALE_MUL  = 11'b00000100000,
    S_SCALE_POST = 11'b00001000000,
    S_RCP_MUL    = 11'b00010000000,
    S_RCP_POST   = 11'b00100000000,
    S_POINT      = 11'b01000000000,
    S_DONE       = 11'b10000000000
  } state_e;

  typedef enum logic [1:0] {
    DIV_ONE = 2'd0,
    DIV_TWO = 2'd1,
    DIV_SIX = 2'd2
  } div_e;

  typedef struct packed {
    ork_pkg::fx_t v;
    logic         ov;
  } sat_t;

  function automatic sat_t sat_fx(input logic signed [SAT_W-1:0] v);
    sat_t                   r;
    logic [SAT_W-DATA_W:0]  hi;
    hi = v[SAT_W-1:DATA_W-1];
    if (hi == '0 || hi == '1) begin
      r.v  = v[DATA_W-1:0];
      r.ov = 1'b0;
    end else begin
      r.v  = v[SAT_W-1] ? FX_MIN : FX_MAX;
      r.ov = 1'b1;
    end
    return r;
  endfunction

  // sign-magnitude quotient back to saturated two's complement
  function automatic sat_t finish(input logic neg, input logic [MAG_W-1:0] mag);
    logic signed [SAT_W-1:0] s;
    s = $signed(SAT_W'(mag));
    if (neg) begin
      s = -s;
    end
    return sat_fx(s);
  endfunction

  state_e                       state_q, state_d;
  ork_pkg::fx_t                 x_q, x_d, y_q, y_d;
  ork_pkg::fx_t                 xe_q, xe_d, ye_q, ye_d;
  ork_pkg::fx_t                 t1_q, t1_d, sv_q, sv_d, k_q, k_d;
  logic signed [ACC_W-1:0]      acc_q, acc_d;
  logic [1:0]                   stage_q, stage_d;
  logic [ork_pkg::STEP_BITS-1:0] steps_q, steps_d;
  logic                         sat_q, sat_d;
  logic [MAG_W-2:0]             n_q, n_d;
  logic                         neg_q, neg_d;

  ork_pkg::mul_req_t            mul_req;
  logic signed [ork_pkg::P_W-1:0] mul_p;

  ork_mul_unit u_mul (
    .clk_i (clk_i),
    .req_i (mul_req),
    .p_o   (mul_p)
  );

  // ---- method decode ----
  logic                    rk4;
  logic [1:0]              last_stage;
  logic                    is_last;
  logic                    weight2;
  div_e                    div_sel;
  logic [ork_pkg::H_W-1:0] x_off;

  always_comb begin
    case (cfg_i.method)
      ork_pkg::METHOD_EULER: begin
        rk4        = 1'b0;
        last_stage = 2'd0;
      end
      ork_pkg::METHOD_HEUN: begin
        rk4        = 1'b0;
        last_stage = 2'd1;
      end
      default: begin
        rk4        = 1'b1;
        last_stage = 2'd3;
      end
    endcase
  end

  assign is_last = (stage_q == last_stage);
  assign weight2 = rk4 && (stage_q == 2'd1 || stage_q == 2'd2);

  always_comb begin
    if (is_last) begin
      if (rk4) div_sel = DIV_SIX;
      else if (cfg_i.method == ork_pkg::METHOD_HEUN) div_sel = DIV_TWO;
      else div_sel = DIV_ONE;
    end else if (rk4 && stage_q != 2'd2) begin
      div_sel = DIV_TWO;
    end else begin
      div_sel = DIV_ONE;
    end
  end

  // midpoint stages of the fourth-order method step by h/2
  assign x_off = (!is_last && rk4 && stage_q != 2'd2) ? (cfg_i.h >> 1) : cfg_i.h;

  // ---- arithmetic around the multiplier ----
  logic signed [Q_W-1:0] q;
  logic                  q_neg;
  logic [Q_W-1:0]        q_mag;
  logic [MAG_W-1:0]      q_clip;
  sat_t                  tri_s, t2_s, k_s, post_one, post_two, rcp_s, xsum, ysum;
  logic signed [ACC_W-1:0] acc_add, k_ext;

  assign q      = mul_p[ork_pkg::P_W-1:ork_pkg::FRAC_BITS];  // floor shift
  assign q_neg  = q[Q_W-1];
  assign q_mag  = q_neg ? Q_W'(-q) : Q_W'(q);
  // anything this large saturates after any of the divides
  assign q_clip = (|q_mag[Q_W-1:MAG_W]) ? '1 : q_mag[MAG_W-1:0];

  assign tri_s    = sat_fx(SAT_W'(xe_q) + (SAT_W'(xe_q) <<< 1));
  assign t2_s     = sat_fx(SAT_W'(q));
  assign k_s      = sat_fx(SAT_W'(t1_q) - SAT_W'(sv_q));
  assign post_one = finish(q_neg, q_clip);
  assign post_two = finish(q_neg, q_clip >> 1);
  assign rcp_s    = finish(neg_q, mul_p[RCP_SHIFT +: MAG_W]);
  assign xsum     = sat_fx(SAT_W'(x_q) + $signed(SAT_W'(x_off)));
  assign ysum     = sat_fx(SAT_W'(y_q) + SAT_W'(sv_q));

  assign k_ext   = ACC_W'(k_q);
  assign acc_add = ((stage_q == 2'd0) ? '0 : acc_q) + (weight2 ? (k_ext <<< 1) : k_ext);

  // ---- sequencer ----
  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    y_d     = y_q;
    xe_d    = xe_q;
    ye_d    = ye_q;
    t1_d    = t1_q;
    sv_d    = sv_q;
    k_d     = k_q;
    acc_d   = acc_q;
    stage_d = stage_q;
    steps_d = steps_q;
    sat_d   = sat_q;
    n_d     = n_q;
    neg_d   = neg_q;
    mul_req = '0;
    in_ready_o     = 1'b0;
    res_o.valid    = 1'b0;
    res_o.y_final  = y_q;
    res_o.overflow = sat_q;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          x_d     = item_i.x_start;
          y_d     = item_i.y_start;
          xe_d    = item_i.x_start;
          ye_d    = item_i.y_start;
          steps_d = item_i.step_count;
          stage_d = 2'd0;
          sat_d   = 1'b0;
          state_d = (item_i.step_count == '0) ? S_DONE : S_EVAL_MUL;
        end
      end
      S_EVAL_MUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = ork_pkg::MA_W'(xe_q);
        mul_req.b  = ork_pkg::MB_W'(ye_q);
        t1_d       = tri_s.v;
        sat_d      = sat_q | tri_s.ov;
        state_d    = S_EVAL_T2;
      end
      S_EVAL_T2: begin
        sv_d    = t2_s.v;
        sat_d   = sat_q | t2_s.ov;
        state_d = S_EVAL_K;
      end
      S_EVAL_K: begin
        k_d     = k_s.v;
        sat_d   = sat_q | k_s.ov;
        state_d = S_ACC;
      end
      S_ACC: begin
        acc_d   = acc_add;
        state_d = S_SCALE_MUL;
      end
      S_SCALE_MUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = ork_pkg::MA_W'(cfg_i.h);
        mul_req.b  = is_last ? acc_q : k_ext;
        state_d    = S_SCALE_POST;
      end
      S_SCALE_POST: begin
        case (div_sel)
          DIV_TWO: begin
            sv_d    = post_two.v;
            sat_d   = sat_q | post_two.ov;
            state_d = S_POINT;
          end
          DIV_SIX: begin
            // halve now, divide by three through the multiplier
            n_d     = q_clip[MAG_W-1:1];
            neg_d   = q_neg;
            state_d = S_RCP_MUL;
          end
          default: begin
            sv_d    = post_one.v;
            sat_d   = sat_q | post_one.ov;
            state_d = S_POINT;
          end
        endcase
      end
      S_RCP_MUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = RECIP3;
        mul_req.b  = ork_pkg::MB_W'(n_q);
        state_d    = S_RCP_POST;
      end
      S_RCP_POST: begin
        sv_d    = rcp_s.v;
        sat_d   = sat_q | rcp_s.ov;
        state_d = S_POINT;
      end
      S_POINT: begin
        xe_d  = xsum.v;
        ye_d  = ysum.v;
        sat_d = sat_q | xsum.ov | ysum.ov;
        if (is_last) begin
          x_d     = xsum.v;
          y_d     = ysum.v;
          stage_d = 2'd0;
          steps_d = steps_q - 1'b1;
          state_d = (steps_q == ork_pkg::STEP_BITS'(1)) ? S_DONE : S_EVAL_MUL;
        end else begin
          stage_d = stage_q + 2'd1;
          state_d = S_EVAL_MUL;
        end
      end
      S_DONE: begin
        res_o.valid = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      stage_q <= 2'd0;
      steps_q <= '0;
      sat_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      stage_q <= stage_d;
      steps_q <= steps_d;
      sat_q   <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    xe_q  <= xe_d;
    ye_q  <= ye_d;
    t1_q  <= t1_d;
    sv_q  <= sv_d;
    k_q   <= k_d;
    acc_q <= acc_d;
    n_q   <= n_d;
    neg_q <= neg_d;
  end

  // ---- assertions ----
  a_steps_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL_MUL) |-> (steps_q != '0))
    else $error("slope evaluation with no steps left");

  a_stage_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL_MUL) |-> (stage_q <= last_stage))
    else $error("slope stage beyond last stage of method");

  a_rcp_only_rk4: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RCP_MUL) |-> (rk4 && is_last && $past(state_q) == S_SCALE_POST))
    else $error("divide by six outside final fourth-order stage");

  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !res_ready_i) |=> (state_q == S_DONE && $stable(y_q)
      && $stable(sat_q)))
    else $error("result changed before handoff");

endmodule

// ===== hw/rtl/ode_runge_kutta_integrator_unit.sv =====
// ============================================================================
// ode_runge_kutta_integrator_unit - fixed-step ODE solver, dy/dx = 3x - xy
// Euler, Heun or fourth-order Runge-Kutta in signed Q16.16 with saturation.
// ============================================================================
// Usage:
//  - in_i (valid/ready): one transaction carries x_start, y_start and
//    step_count. It is taken only while the core is idle.
//  - out_o (valid/ready): one transaction per input with y_final and the
//    overflow flag (set if any intermediate value clamped during the run).
//  - APB port: reg 0 (addr 0x0) step_size, unsigned Q3.16, 19 bits;
//    reg 1 (addr 0x4) method: 0 Euler, 1 Heun, 2/3 fourth order.
//    Write only while no run is in flight.
//  - Every step runs its slope stages through one shared 33x36 multiplier.
//    A slope stage runs x*y, slope, sum, h*k and the point update in order;
//    the final fourth-order stage adds the reciprocal divide by 3.
//  - A step_count of 0 runs no step. The next input is accepted the cycle
//    after the result moves into the output register.
//  - Output stall: the result waits in the output register; the core may
//    take and run the next item, then holds its result until the slot frees.
//  - Reset: step_size 6554 (about 0.1), method fourth order, channels empty.
// ============================================================================
module ode_runge_kutta_integrator_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  ork_in_if.sink                       in_i,
  ork_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ork_pkg::PADDR_W-1:0]  paddr,
  input  logic [ork_pkg::PDATA_W-1:0]  pwdata,
  output logic [ork_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  ork_pkg::cfg_t  cfg;
  ork_pkg::item_t item;
  ork_pkg::res_t  res;
  logic           slot_free;

  logic           out_valid_q;
  ork_pkg::fx_t   y_final_q;
  logic           overflow_q;

  ork_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign item.x_start    = in_i.x_start;
  assign item.y_start    = in_i.y_start;
  assign item.step_count = in_i.step_count;

  ork_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .item_i      (item),
    .res_o       (res),
    .res_ready_i (slot_free)
  );

  // output register: frees the core while the sink stalls
  assign slot_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid && slot_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && slot_free) begin
      y_final_q  <= res.y_final;
      overflow_q <= res.overflow;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.y_final  = y_final_q;
  assign out_o.overflow = overflow_q;

endmodule

// ===== tb/ode_runge_kutta_integrator_unit_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// ode_runge_kutta_integrator_unit_tb - self-checking bench of the ODE solver
// Drives start points through the input channel, writes step size and method
// over APB between phases, and checks every final y and overflow flag against
// an in-bench fixed-point integrator of dy/dx = 3x - xy.
// ============================================================================
module ode_runge_kutta_integrator_unit_tb;

  // Method code with no name of its own; the core runs it as fourth order
  localparam logic [1:0] METHOD_RK4_ALT = 2'd3;

  localparam int           FX_ONE           = 1 << ork_pkg::FRAC_BITS;
  localparam longint       FX_HI            = 64'sd2147483647;
  localparam longint       FX_LO            = -64'sd2147483648;
  localparam ork_pkg::fx_t FX_MAX_V         = 32'sh7FFF_FFFF;
  localparam ork_pkg::fx_t FX_MIN_V         = 32'sh8000_0000;
  localparam int           SINK_HOLD_CYCLES = 400;
  localparam int           H_MAX            = 262144;

  typedef struct packed {
    ork_pkg::fx_t y_final;
    logic         overflow;
  } run_result_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [ork_pkg::PADDR_W-1:0] paddr;
  logic [ork_pkg::PDATA_W-1:0] pwdata;
  logic [ork_pkg::PDATA_W-1:0] prdata;
  logic                        pready;

  ork_in_if  in_if ();
  ork_out_if out_if ();

  ode_runge_kutta_integrator_unit u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Integrator mirror: own copy of the registers and of the per-run state.
  // All math in 64-bit signed; every clamp marks the run as saturated.
  // --------------------------------------------------------------------------
  logic [ork_pkg::H_W-1:0] pred_h      = ork_pkg::H_RESET;
  logic [1:0]              pred_method = ork_pkg::METHOD_RK4;
  longint                  run_x;
  longint                  run_y;
  bit                      run_clamped;

  function automatic longint clamp32(longint v);
    if (v > FX_HI) begin
      run_clamped = 1'b1;
      return FX_HI;
    end
    if (v < FX_LO) begin
      run_clamped = 1'b1;
      return FX_LO;
    end
    return v;
  endfunction

  // (a*b) >>> FRAC_BITS rounds toward minus infinity; the divide truncates
  function automatic longint mul_shift(longint a, longint b, longint div);
    longint q;
    q = (a * b) >>> ork_pkg::FRAC_BITS;
    return clamp32(q / div);
  endfunction

  // f(x,y) = 3x - xy with each term clamped
  function automatic longint slope_at(longint x, longint y);
    longint t1;
    longint t2;
    t1 = clamp32(3 * x);
    t2 = mul_shift(x, y, 1);
    return clamp32(t1 - t2);
  endfunction

  function automatic run_result_t integrate_run(ork_pkg::item_t it);
    longint      h;
    longint      half;
    longint      x;
    longint      y;
    longint      xm;
    longint      k1;
    longint      k2;
    longint      k3;
    longint      k4;
    run_result_t r;
    h           = longint'(pred_h);
    half        = longint'(pred_h >> 1);
    run_x       = longint'(it.x_start);
    run_y       = longint'(it.y_start);
    run_clamped = 1'b0;
    for (int n = 0; n < int'(it.step_count); n++) begin
      x  = run_x;
      y  = run_y;
      k1 = slope_at(x, y);
      case (pred_method)
        ork_pkg::METHOD_EULER: begin
          run_y = clamp32(y + mul_shift(h, k1, 1));
        end
        ork_pkg::METHOD_HEUN: begin
          k2    = slope_at(clamp32(x + h), clamp32(y + mul_shift(h, k1, 1)));
          run_y = clamp32(y + mul_shift(h, k1 + k2, 2));
        end
        default: begin
          // fourth order; the spare code lands here too
          xm    = clamp32(x + half);
          k2    = slope_at(xm, clamp32(y + mul_shift(h, k1, 2)));
          k3    = slope_at(xm, clamp32(y + mul_shift(h, k2, 2)));
          k4    = slope_at(clamp32(x + h), clamp32(y + mul_shift(h, k3, 1)));
          run_y = clamp32(y + mul_shift(h, k1 + 2 * k2 + 2 * k3 + k4, 6));
        end
      endcase
      run_x = clamp32(x + h);
    end
    r.y_final  = ork_pkg::fx_t'(run_y);
    r.overflow = run_clamped;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  ork_pkg::item_t pending_items[$];    // start points not yet offered
  run_result_t    expected_finals[$];  // one per accepted transaction, in order
  ork_pkg::item_t offered;
  run_result_t    want;
  int             idle_pct       = 20;  // idle chance per cycle, both sides
  int             hold_requests  = 0;   // bumped to ask the sink for a long hold
  int             hold_grants    = 0;
  int             sink_hold_left = 0;
  int             mismatch_count = 0;
  int             runs_accepted  = 0;
  int             runs_checked   = 0;
  int             runs_clamped   = 0;
  int             settings_seen  = 1;   // reset setting counts as the first

  // --------------------------------------------------------------------------
  // Driver: holds valid until the transaction is taken, then maybe idles.
  // The expected result is computed at the accepting edge.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_finals.push_back(integrate_run(offered));
        runs_accepted++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
          offered          = pending_items.pop_front();
          in_if.valid      <= 1'b1;
          in_if.x_start    <= offered.x_start;
          in_if.y_start    <= offered.y_start;
          in_if.step_count <= offered.step_count;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sink: random ready, plus a long hold on request so the output register
  // and the core both fill up and the input channel stalls.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (sink_hold_left != 0) begin
      out_if.ready   <= 1'b0;
      sink_hold_left <= sink_hold_left - 1;
    end else if (hold_grants != hold_requests) begin
      out_if.ready   <= 1'b0;
      sink_hold_left <= SINK_HOLD_CYCLES;
      hold_grants    <= hold_requests;
    end else begin
      out_if.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every result transaction against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_finals.size() == 0) begin
        $error("result with no run outstanding: y_final=%0d overflow=%0b",
               out_if.y_final, out_if.overflow);
        mismatch_count++;
      end else begin
        want = expected_finals.pop_front();
        runs_checked++;
        if (want.overflow) runs_clamped++;
        if (out_if.y_final !== want.y_final) begin
          $error("y_final: expected %0d, got %0d", want.y_final, out_if.y_final);
          mismatch_count++;
        end
        if (out_if.overflow !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, out_if.overflow);
          mismatch_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void push_run(ork_pkg::fx_t x, ork_pkg::fx_t y, int steps);
    ork_pkg::item_t it;
    it.x_start    = x;
    it.y_start    = y;
    it.step_count = ork_pkg::STEP_BITS'(steps);
    pending_items.push_back(it);
  endfunction

  // Mostly a few units around zero, sometimes the full 32-bit range
  function automatic ork_pkg::fx_t rand_fx(int mag);
    int span;
    span = mag * FX_ONE;
    if ($urandom_range(9) < 3) return ork_pkg::fx_t'($urandom);
    return ork_pkg::fx_t'(int'($urandom_range(2 * span, 0)) - span);
  endfunction

  // Short runs keep the bench fast; a few draw from the full step-count range
  function automatic void push_random_runs(int count, int max_steps);
    int steps;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 4) steps = $urandom_range(1023, 0);
      else steps = $urandom_range(max_steps, 0);
      push_run(rand_fx(4), rand_fx(16), steps);
    end
  endfunction

  // Setup cycle, access cycle, register taken once pready is seen
  task automatic apb_write(input logic reg_idx, input logic [ork_pkg::PDATA_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ork_pkg::PADDR_W'({reg_idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == ork_pkg::REG_STEP_SIZE) pred_h = value[ork_pkg::H_W-1:0];
    else pred_method = value[1:0];
  endtask

  // Only called with the core idle
  task automatic set_config(input int h, input logic [1:0] m);
    apb_write(ork_pkg::REG_STEP_SIZE, ork_pkg::PDATA_W'(h));
    apb_write(ork_pkg::REG_METHOD, ork_pkg::PDATA_W'(m));
    settings_seen++;
    @(negedge clk_i);
  endtask

  // Checked at negedge so no queue is read while a clocked block updates it
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || in_if.valid || expected_finals.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_if.valid      = 1'b0;
    in_if.x_start    = '0;
    in_if.y_start    = '0;
    in_if.step_count = '0;
    out_if.ready     = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset setting (h about 0.1, fourth order): extremes, zero steps,
    // saturation from the first slope, one full-length run
    push_run(FX_MIN_V, FX_MAX_V, 0);
    push_run('0, '0, 1);
    push_run(ork_pkg::fx_t'(FX_ONE), ork_pkg::fx_t'(2 * FX_ONE), 10);
    push_run(FX_MAX_V, FX_MAX_V, 1);
    push_run(FX_MIN_V, FX_MIN_V, 2);
    push_run(ork_pkg::fx_t'(FX_ONE / 2), ork_pkg::fx_t'(-3 * FX_ONE), 1023);
    push_run(ork_pkg::fx_t'(-FX_ONE), ork_pkg::fx_t'(3 * FX_ONE), 5);
    wait_drained();

    // Euler, smallest nonzero step
    set_config(1, ork_pkg::METHOD_EULER);
    push_run(FX_MAX_V, '0, 1);
    push_run(ork_pkg::fx_t'(FX_ONE), FX_MIN_V, 3);
    push_run(FX_MIN_V, FX_MAX_V, 1023);
    push_random_runs(15, 12);
    wait_drained();

    // Heun, step h = 4.0: diverges and clamps quickly
    set_config(H_MAX, ork_pkg::METHOD_HEUN);
    push_run(ork_pkg::fx_t'(FX_ONE), ork_pkg::fx_t'(FX_ONE), 4);
    push_run(FX_MAX_V, FX_MIN_V, 2);
    push_run(ork_pkg::fx_t'(-2 * FX_ONE), '0, 0);
    push_random_runs(15, 12);
    wait_drained();

    // Zero step: x never moves, y only by zero-width steps
    set_config(0, ork_pkg::METHOD_RK4);
    push_run(ork_pkg::fx_t'(3 * FX_ONE / 2), ork_pkg::fx_t'(-5 * FX_ONE / 2), 7);
    push_run(FX_MAX_V, FX_MAX_V, 2);
    push_random_runs(10, 12);
    wait_drained();

    // Spare method code, h = 1.0; sink held off while the source keeps
    // offering short runs, so the input channel has to stall
    set_config(FX_ONE, METHOD_RK4_ALT);
    idle_pct = 0;
    hold_requests++;
    push_run(ork_pkg::fx_t'(FX_ONE / 2), ork_pkg::fx_t'(FX_ONE / 2), 3);
    push_random_runs(14, 3);
    wait_drained();
    idle_pct = 20;

    // Random settings; the middle one runs with no idling at all
    for (int p = 0; p < 3; p++) begin
      set_config(($urandom_range(1) != 0) ? $urandom_range(H_MAX, 1) : $urandom_range(16384, 1),
                 2'($urandom_range(3, 0)));
      idle_pct = (p == 1) ? 0 : 20;
      push_random_runs(10, 12);
      wait_drained();
    end
    idle_pct = 20;

    // Tail: catch any stray result beyond the last expected one
    repeat (40) @(posedge clk_i);

    $display("Checked %0d of %0d runs (%0d with saturation) across %0d step/method settings,",
             runs_checked, runs_accepted, runs_clamped, settings_seen);
    $display("incl. Euler, Heun, fourth order, spare code, zero h, zero steps, long sink hold.");
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #200_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/ork_pkg.sv
hw/rtl/ork_in_if.sv
hw/rtl/ork_out_if.sv
hw/rtl/ork_mul_unit.sv
hw/rtl/ork_cfg_regs.sv
hw/rtl/ork_core.sv
hw/rtl/ode_runge_kutta_integrator_unit.sv
tb/ode_runge_kutta_integrator_unit_tb.sv
